FILE: design/prs_pkg.sv
// shared types, constants and codes for the paged range splitter
package prs_pkg;

  // default geometry
  localparam int PAGE_BITS_DEF = 10;
  localparam int ADDR_BITS_DEF = 32;

  // fixed field widths
  localparam int ADDR_W = 32;
  localparam int LEN_W  = 25;
  localparam int PNUM_W = 12;
  localparam int POFF_W = 22;
  localparam int CLEN_W = 23;
  localparam int STAT_W = 2;

  // stream bus widths
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 64;

  // largest byte count of one request
  localparam logic [LEN_W-1:0] LEN_MAX = 25'h100_0000;

  // result status codes
  localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_UNALLOC = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_WRAP    = 2'd2;

  // request kinds
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_RD,
    ST_CHK,
    ST_WRAP
  } prs_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic clr;        // clear one bitmap entry, step the sweep counter
    logic load;       // take the input transfer
    logic setup;      // work out end page and wrap
    logic rd;         // read the bitmap bit of the current page
    logic emit;       // load the current chunk into the output register
    logic emit_wrap;  // load the wrap error result
  } prs_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_done;   // sweep at last entry
    logic len_zero;   // request carries no bytes
    logic wrap;       // range passes the top of the address space
    logic final_pg;   // current page is the last one of the range
    logic unalloc;    // read of an unallocated page
    logic out_free;   // output register can take a result
  } prs_stat_t;

endpackage

FILE: design/prs_ctrl.sv
// controller state machine for the paged range splitter
module prs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  prs_pkg::prs_stat_t  stat,
  output prs_pkg::prs_cmd_t   cmd
);

  prs_pkg::prs_state_t state_r;
  prs_pkg::prs_state_t state_nxt;

  // state register, clearing sweep first after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= prs_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      prs_pkg::ST_CLEAR: begin
        if (stat.clr_done) state_nxt = prs_pkg::ST_IDLE;
      end
      prs_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = prs_pkg::ST_SETUP;
      end
      prs_pkg::ST_SETUP: begin
        if (stat.len_zero) begin
          state_nxt = prs_pkg::ST_IDLE;
        end else if (stat.wrap) begin
          state_nxt = prs_pkg::ST_WRAP;
        end else begin
          state_nxt = prs_pkg::ST_RD;
        end
      end
      prs_pkg::ST_RD: begin
        state_nxt = prs_pkg::ST_CHK;
      end
      prs_pkg::ST_CHK: begin
        if (stat.out_free) begin
          if (stat.final_pg || stat.unalloc) begin
            state_nxt = prs_pkg::ST_IDLE;
          end else begin
            state_nxt = prs_pkg::ST_RD;
          end
        end
      end
      prs_pkg::ST_WRAP: begin
        if (stat.out_free) state_nxt = prs_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = prs_pkg::ST_CLEAR;
      end
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      prs_pkg::ST_CLEAR: begin
        cmd.clr = 1'b1;
      end
      prs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      prs_pkg::ST_SETUP: begin
        cmd.setup = 1'b1;
      end
      prs_pkg::ST_RD: begin
        cmd.rd = 1'b1;
      end
      prs_pkg::ST_CHK: begin
        cmd.emit = stat.out_free;
      end
      prs_pkg::ST_WRAP: begin
        cmd.emit_wrap = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: design/prs_dp.sv
// datapath of the paged range splitter: request registers, chunk arithmetic,
// page bitmap and output register
module prs_dp #(
  parameter int PAGE_BITS = prs_pkg::PAGE_BITS_DEF,
  parameter int ADDR_BITS = prs_pkg::ADDR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_func,
  input  logic [prs_pkg::ADDR_W-1:0]    in_addr,
  input  logic [prs_pkg::LEN_W-1:0]     in_length,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [prs_pkg::PNUM_W-1:0]    out_page_num,
  output logic [prs_pkg::POFF_W-1:0]    out_page_offset,
  output logic [prs_pkg::CLEN_W-1:0]    out_chunk_len,
  output logic [prs_pkg::STAT_W-1:0]    out_status,
  output logic                          out_last,
  input  prs_pkg::prs_cmd_t             cmd,
  output prs_pkg::prs_stat_t            stat
);

  localparam int AW       = ADDR_BITS;
  localparam int OFF_BITS = ADDR_BITS - PAGE_BITS;
  localparam int NUM_PAGES = 1 << PAGE_BITS;
  localparam int LW       = prs_pkg::LEN_W;
  localparam int SW       = ((AW > LW) ? AW : LW) + 1;
  localparam int CW       = ((OFF_BITS + 1) > LW) ? (OFF_BITS + 1) : LW;

  // request registers
  logic                   func_r;
  logic [PAGE_BITS-1:0]   page_r;
  logic [PAGE_BITS-1:0]   last_page_r;
  logic [OFF_BITS-1:0]    off_r;
  logic [LW-1:0]          left_r;
  logic [AW-1:0]          base_r;

  // page bitmap and sweep counter
  logic                   page_map [NUM_PAGES];
  logic                   rd_bit_r;
  logic [PAGE_BITS-1:0]   clr_idx_r;

  // output register
  logic                   out_valid_r;
  logic [prs_pkg::PNUM_W-1:0] out_page_num_r;
  logic [prs_pkg::POFF_W-1:0] out_page_offset_r;
  logic [prs_pkg::CLEN_W-1:0] out_chunk_len_r;
  logic [prs_pkg::STAT_W-1:0] out_status_r;
  logic                   out_last_r;

  // combinational helpers
  logic [AW-1:0]          addr_m;
  logic [LW-1:0]          len_sat;
  logic [SW-1:0]          end_addr;
  logic [CW-1:0]          room;
  logic [CW-1:0]          left_w;
  logic [CW-1:0]          chunk_w;
  logic [LW-1:0]          chunk;
  logic                   unalloc;
  logic                   final_pg;

  // address masked to the address space, length saturated
  always_comb begin
    addr_m  = AW'(in_addr);
    len_sat = in_length[LW-1] ? prs_pkg::LEN_MAX : in_length;
  end

  // last byte address, carry above the space means wrap
  assign end_addr = SW'(base_r) + SW'(left_r) - SW'(1);

  // chunk length: rest of the page or rest of the range
  always_comb begin
    room    = (CW'(1) << OFF_BITS) - CW'(off_r);
    left_w  = CW'(left_r);
    chunk_w = (room < left_w) ? room : left_w;
    chunk   = LW'(chunk_w);
  end

  assign unalloc  = (func_r == prs_pkg::FUNC_READ) && !rd_bit_r;
  assign final_pg = (page_r == last_page_r);

  // request registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      base_r <= addr_m;
      page_r <= addr_m[AW-1:OFF_BITS];
      off_r  <= addr_m[OFF_BITS-1:0];
      left_r <= len_sat;
    end else if (cmd.emit) begin
      page_r <= page_r + PAGE_BITS'(1);
      off_r  <= '0;
      left_r <= left_r - chunk;
    end
    if (cmd.setup) begin
      last_page_r <= end_addr[AW-1:OFF_BITS];
    end
  end

  // sweep counter for the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clr) begin
      clr_idx_r <= clr_idx_r + PAGE_BITS'(1);
    end
  end

  // page bitmap: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      page_map[clr_idx_r] <= 1'b0;
    end else if (cmd.emit && (func_r == prs_pkg::FUNC_WRITE)) begin
      page_map[page_r] <= 1'b1;
    end
    if (cmd.rd) begin
      rd_bit_r <= page_map[page_r];
    end
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.emit_wrap) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_page_num_r    <= prs_pkg::PNUM_W'(page_r);
      out_page_offset_r <= prs_pkg::POFF_W'(off_r);
      out_chunk_len_r   <= prs_pkg::CLEN_W'(chunk);
      out_status_r      <= unalloc ? prs_pkg::STATUS_UNALLOC : prs_pkg::STATUS_OK;
      out_last_r        <= final_pg || unalloc;
    end else if (cmd.emit_wrap) begin
      out_page_num_r    <= prs_pkg::PNUM_W'(page_r);
      out_page_offset_r <= prs_pkg::POFF_W'(off_r);
      out_chunk_len_r   <= '0;
      out_status_r      <= prs_pkg::STATUS_WRAP;
      out_last_r        <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_page_num    = out_page_num_r;
  assign out_page_offset = out_page_offset_r;
  assign out_chunk_len   = out_chunk_len_r;
  assign out_status      = out_status_r;
  assign out_last        = out_last_r;

  // status to the controller
  always_comb begin
    stat.clr_done = &clr_idx_r;
    stat.len_zero = (left_r == '0);
    stat.wrap     = (end_addr[SW-1:AW] != '0);
    stat.final_pg = final_pg;
    stat.unalloc  = unalloc;
    stat.out_free = !out_valid_r || out_ready;
  end

endmodule

FILE: design/paged_range_splitter_top.sv
// top level of the paged range splitter
//
// Each transfer on the in_ channel is one read or write request: kind on
// in_tuser, start byte address and byte count on in_tdata. The range is cut
// at page boundaries and one result per page touched leaves on the out_
// channel with page number, in-page offset, chunk length and status; out_tlast
// marks the final result of a request. Writes mark their pages allocated in
// a page bitmap; a read reaching an unallocated page ends with status 1, a
// range passing the top of the address space gives one result with status 2,
// a zero length gives nothing.
// A request passes through accept and setup, then a bitmap read and a check
// per chunk, since the single-port bitmap is read once per chunk; a zero
// length ends after setup, a wrap goes from setup to its result. A new
// request is taken only after the last result of the current one is loaded.
// After reset the bitmap is cleared one page a cycle, all 2^PAGE_BITS pages
// (1024 by default), with in_tready low. A stalled receiver holds the result
// in the output register; the next chunk waits until that register is free.
module paged_range_splitter_top #(
  parameter int PAGE_BITS = prs_pkg::PAGE_BITS_DEF,
  parameter int ADDR_BITS = prs_pkg::ADDR_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [prs_pkg::IN_TDATA_W-1:0]   in_tdata,   // addr[31:0], length[56:32]
  input  logic                             in_tuser,   // func
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [prs_pkg::OUT_TDATA_W-1:0]  out_tdata,  // page_num[11:0],
                                                       // page_offset[33:12],
                                                       // chunk_len[56:34],
                                                       // status[58:57]
  output logic                             out_tlast   // last
);

  localparam int LEN_LO  = prs_pkg::ADDR_W;
  localparam int POFF_LO = prs_pkg::PNUM_W;
  localparam int CLEN_LO = POFF_LO + prs_pkg::POFF_W;
  localparam int STAT_LO = CLEN_LO + prs_pkg::CLEN_W;
  localparam int PAD_LO  = STAT_LO + prs_pkg::STAT_W;

  prs_pkg::prs_cmd_t           cmd;
  prs_pkg::prs_stat_t          stat;
  logic [prs_pkg::PNUM_W-1:0]  page_num;
  logic [prs_pkg::POFF_W-1:0]  page_offset;
  logic [prs_pkg::CLEN_W-1:0]  chunk_len;
  logic [prs_pkg::STAT_W-1:0]  status;

  // controller
  prs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  prs_dp #(
    .PAGE_BITS (PAGE_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_func         (in_tuser),
    .in_addr         (in_tdata[LEN_LO-1:0]),
    .in_length       (in_tdata[LEN_LO+prs_pkg::LEN_W-1:LEN_LO]),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_page_num    (page_num),
    .out_page_offset (page_offset),
    .out_chunk_len   (chunk_len),
    .out_status      (status),
    .out_last        (out_tlast),
    .cmd             (cmd),
    .stat            (stat)
  );

  // pack result fields
  assign out_tdata = {{(prs_pkg::OUT_TDATA_W - PAD_LO){1'b0}},
                      status, chunk_len, page_offset, page_num};

  // wrap error is a single empty result closing the request
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (status == prs_pkg::STATUS_WRAP)) |->
      (out_tlast && (chunk_len == '0)))
    else $error("wrap result not final or not empty");

  // unallocated read ends the run
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (status == prs_pkg::STATUS_UNALLOC)) |-> out_tlast)
    else $error("unallocated read result not final");

  // every chunk of a valid range carries bytes
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (status != prs_pkg::STATUS_WRAP)) |-> (chunk_len != '0))
    else $error("empty chunk emitted");

  // no new request while a result is being loaded
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit || cmd.emit_wrap) |-> !in_tready)
    else $error("input taken during result load");

endmodule
